// ----- src/jbbp_pkg.sv -----
package jbbp_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam logic [7:0] RAW_PUSH_RESET = 8'hFE;

    localparam logic [7:0] OP_IINC    = 8'h84;
    localparam logic [7:0] OP_WIDE    = 8'hC4;
    localparam logic [7:0] OP_TSWITCH = 8'hAA;
    localparam logic [7:0] OP_GOTO_W  = 8'hC8;
    localparam logic [7:0] OP_JSR_W   = 8'hC9;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN = 3'd1;
    localparam logic [2:0] ERR_WIDE2   = 3'd2;
    localparam logic [2:0] ERR_BADWIDE = 3'd3;
    localparam logic [2:0] ERR_LONG    = 3'd4;

    localparam logic [1:0] KIND_BRANCH  = 2'd0;
    localparam logic [1:0] KIND_DEFAULT = 2'd1;
    localparam logic [1:0] KIND_TCASE   = 2'd2;
    localparam logic [1:0] KIND_LPAIR   = 2'd3;

    typedef enum logic [11:0] {
        PH_OPCODE    = 12'b000000000001,
        PH_WIDE_OP   = 12'b000000000010,
        PH_OPERANDS  = 12'b000000000100,
        PH_BRANCH    = 12'b000000001000,
        PH_PAD       = 12'b000000010000,
        PH_DEFAULT   = 12'b000000100000,
        PH_TS_LOW    = 12'b000001000000,
        PH_TS_HIGH   = 12'b000010000000,
        PH_TS_CASE   = 12'b000100000000,
        PH_LS_NPAIRS = 12'b001000000000,
        PH_LS_MATCH  = 12'b010000000000,
        PH_LS_OFFSET = 12'b100000000000
    } phase_t;

    typedef enum logic [2:0] {
        CL_UNKNOWN = 3'd0,
        CL_FIXED   = 3'd1,
        CL_LOCAL   = 3'd2,
        CL_IINC    = 3'd3,
        CL_FIELD   = 3'd4,
        CL_BR16    = 3'd5,
        CL_BR32    = 3'd6,
        CL_SWITCH  = 3'd7
    } op_class_t;

    typedef struct packed {
        op_class_t  cls;
        logic [2:0] len;
    } op_info_t;

    // Opcode class and fixed operand count
    function automatic op_info_t classify(input logic [7:0] b);
        op_info_t r;
        r.cls = CL_UNKNOWN;
        r.len = 3'd0;
        if (b <= 8'h0F || (b >= 8'h1A && b <= 8'h35) || (b >= 8'h3B && b <= 8'h83) ||
            (b >= 8'h85 && b <= 8'h98) || (b >= 8'hAC && b <= 8'hB1) ||
            b == 8'hBE || b == 8'hBF || b == 8'hC2 || b == 8'hC3) begin
            r.cls = CL_FIXED;
        end else if (b == 8'h10 || b == 8'h12 || b == 8'hBC) begin
            r.cls = CL_FIXED; r.len = 3'd1;
        end else if (b == 8'h11 || b == 8'h13 || b == 8'h14 || b == 8'hB6 ||
                     b == 8'hBB || b == 8'hBD || b == 8'hC0 || b == 8'hC1) begin
            r.cls = CL_FIXED; r.len = 3'd2;
        end else if (b == 8'hC5) begin
            r.cls = CL_FIXED; r.len = 3'd3;
        end else if (b == 8'hB9 || b == 8'hBA) begin
            r.cls = CL_FIXED; r.len = 3'd4;
        end else if ((b >= 8'h15 && b <= 8'h19) || (b >= 8'h36 && b <= 8'h3A) ||
                     b == 8'hA9) begin
            r.cls = CL_LOCAL;
        end else if (b == OP_IINC) begin
            r.cls = CL_IINC;
        end else if ((b >= 8'hB2 && b <= 8'hB5) || b == 8'hB7 || b == 8'hB8) begin
            r.cls = CL_FIELD;
        end else if ((b >= 8'h99 && b <= 8'hA8) || b == 8'hC6 || b == 8'hC7) begin
            r.cls = CL_BR16;
        end else if (b == OP_GOTO_W || b == OP_JSR_W) begin
            r.cls = CL_BR32;
        end else if (b == OP_TSWITCH || b == 8'hAB) begin
            r.cls = CL_SWITCH;
        end
        return r;
    endfunction

endpackage

// ----- src/jvm_bytecode_boundary_parser.sv -----
// Each result item is registered and turns valid in the cycle after its input item is accepted.
// Throughput: one byte per cycle; the result register is a single stage that
// refills in the same cycle it is taken, so s_ready stays high unless a result waits.
// Reset (aresetn low, synchronous): parser returns to expecting an opcode at
// offset 0, errors clear, raw push opcode returns to 0xFE.
module jvm_bytecode_boundary_parser #(
    parameter int ADDR_BITS = jbbp_pkg::ADDR_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_code_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [15:0]  m_byte_offset,
    output logic         m_instr_start,
    output logic         m_instr_end,
    output logic [7:0]   m_opcode,
    output logic         m_is_wide,
    output logic         m_target_valid,
    output logic [1:0]   m_target_kind,
    output logic [31:0]  m_target,
    output logic [31:0]  m_case_key,
    output logic [2:0]   m_error_code
);
    import jbbp_pkg::*;

    localparam logic [ADDR_BITS:0] LIMIT = {1'b1, {ADDR_BITS{1'b0}}};

    logic [7:0]           raw_push_reg;
    logic [ADDR_BITS:0]   pos_reg, pos_next;
    phase_t               ph_reg, ph_next;
    logic [7:0]           cop_reg, cop_next;
    logic [ADDR_BITS-1:0] iaddr_reg, iaddr_next;
    logic                 wide_reg, wide_next;
    logic [2:0]           obl_reg, obl_next;
    logic [1:0]           pad_reg, pad_next;
    logic [31:0]          acc_reg, acc_next;
    logic [1:0]           wbc_reg, wbc_next;
    logic [31:0]          key_reg, key_next;
    logic [31:0]          cnt_reg, cnt_next;
    logic [2:0]           err_reg, err_next;

    logic        start, fin, tv;
    logic [1:0]  kind;
    logic [31:0] tgt, key, ofs, w, iaddr32;
    logic [2:0]  len;
    logic        word_done;
    op_info_t    info;
    logic        accept;

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;
    assign iaddr32 = 32'(iaddr_next);

    // Decode one byte against the parser state
    always_comb begin
        pos_next = pos_reg; ph_next = ph_reg; cop_next = cop_reg;
        iaddr_next = iaddr_reg; wide_next = wide_reg; obl_next = obl_reg;
        pad_next = pad_reg; acc_next = acc_reg; wbc_next = wbc_reg;
        key_next = key_reg; cnt_next = cnt_reg; err_next = err_reg;
        start = 1'b0; fin = 1'b0; tv = 1'b0; kind = KIND_BRANCH;
        tgt = '0; key = '0; word_done = 1'b0; len = 3'd0; ofs = '0;
        info = classify(s_code_byte);
        w = {acc_reg[23:0], s_code_byte};

        if (err_next == ERR_NONE && pos_reg >= LIMIT) err_next = ERR_LONG;

        if (err_next == ERR_NONE) begin
            unique case (ph_reg)
                PH_OPCODE, PH_WIDE_OP: begin
                    if (ph_reg == PH_OPCODE) begin
                        iaddr_next = pos_reg[ADDR_BITS-1:0];
                        wide_next = 1'b0;
                        start = 1'b1;
                    end
                    cop_next = s_code_byte;
                    if (s_code_byte == raw_push_reg) begin
                        if (wide_next) err_next = ERR_BADWIDE;
                        else begin ph_next = PH_OPERANDS; obl_next = 3'd4; end
                    end else if (s_code_byte == OP_WIDE) begin
                        if (wide_next) err_next = ERR_WIDE2;
                        else begin wide_next = 1'b1; ph_next = PH_WIDE_OP; end
                    end else if (info.cls == CL_UNKNOWN) begin
                        err_next = ERR_UNKNOWN;
                    end else if (wide_next && info.cls != CL_LOCAL &&
                                 info.cls != CL_IINC && info.cls != CL_FIELD) begin
                        err_next = ERR_BADWIDE;
                    end else begin
                        len = info.len;
                        if (info.cls == CL_LOCAL) len = wide_next ? 3'd2 : 3'd1;
                        else if (info.cls == CL_IINC) len = wide_next ? 3'd4 : 3'd2;
                        else if (info.cls == CL_FIELD) len = wide_next ? 3'd3 : 3'd2;
                        if (info.cls == CL_BR16 || info.cls == CL_BR32) begin
                            ph_next = PH_BRANCH;
                            obl_next = (info.cls == CL_BR16) ? 3'd2 : 3'd4;
                            acc_next = '0;
                        end else if (info.cls == CL_SWITCH) begin
                            pad_next = 2'd3 - iaddr_next[1:0];
                            acc_next = '0;
                            wbc_next = '0;
                            ph_next = (pad_next != 2'd0) ? PH_PAD : PH_DEFAULT;
                        end else if (len == 3'd0) begin
                            fin = 1'b1; ph_next = PH_OPCODE;
                        end else begin
                            ph_next = PH_OPERANDS; obl_next = len;
                        end
                    end
                end
                PH_OPERANDS: begin
                    obl_next = obl_reg - 3'd1;
                    if (obl_next == 3'd0) begin fin = 1'b1; ph_next = PH_OPCODE; end
                end
                PH_BRANCH: begin
                    acc_next = w;
                    obl_next = obl_reg - 3'd1;
                    if (obl_next == 3'd0) begin
                        ofs = w;
                        if (cop_reg != OP_GOTO_W && cop_reg != OP_JSR_W)
                            ofs = {{16{w[15]}}, w[15:0]};
                        tv = 1'b1; kind = KIND_BRANCH; tgt = iaddr32 + ofs;
                        fin = 1'b1; ph_next = PH_OPCODE;
                    end
                end
                PH_PAD: begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_next == 2'd0) ph_next = PH_DEFAULT;
                end
                default: begin
                    acc_next = w;
                    word_done = (wbc_reg == 2'd3);
                    wbc_next = wbc_reg + 2'd1;
                end
            endcase

            // Complete a switch word
            if (word_done) begin
                unique case (ph_reg)
                    PH_DEFAULT: begin
                        tv = 1'b1; kind = KIND_DEFAULT; tgt = iaddr32 + w;
                        ph_next = (cop_reg == OP_TSWITCH) ? PH_TS_LOW : PH_LS_NPAIRS;
                    end
                    PH_TS_LOW: begin
                        key_next = w; ph_next = PH_TS_HIGH;
                    end
                    PH_TS_HIGH: begin
                        cnt_next = w - key_reg + 32'd1;
                        if (cnt_next == '0) begin fin = 1'b1; ph_next = PH_OPCODE; end
                        else ph_next = PH_TS_CASE;
                    end
                    PH_TS_CASE: begin
                        tv = 1'b1; kind = KIND_TCASE; tgt = iaddr32 + w; key = key_reg;
                        key_next = key_reg + 32'd1;
                        cnt_next = cnt_reg - 32'd1;
                        if (cnt_next == '0) begin fin = 1'b1; ph_next = PH_OPCODE; end
                    end
                    PH_LS_NPAIRS: begin
                        cnt_next = w;
                        if (w == '0) begin fin = 1'b1; ph_next = PH_OPCODE; end
                        else ph_next = PH_LS_MATCH;
                    end
                    PH_LS_MATCH: begin
                        key_next = w; ph_next = PH_LS_OFFSET;
                    end
                    default: begin
                        tv = 1'b1; kind = KIND_LPAIR; tgt = iaddr32 + w; key = key_reg;
                        cnt_next = cnt_reg - 32'd1;
                        if (cnt_next == '0) begin fin = 1'b1; ph_next = PH_OPCODE; end
                        else ph_next = PH_LS_MATCH;
                    end
                endcase
            end
        end

        if (pos_reg < LIMIT) pos_next = pos_reg + 1'b1;
    end

    // Advance parser state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_push_reg <= RAW_PUSH_RESET;
            pos_reg <= '0; ph_reg <= PH_OPCODE; cop_reg <= '0; iaddr_reg <= '0;
            wide_reg <= 1'b0; obl_reg <= '0; pad_reg <= '0; acc_reg <= '0;
            wbc_reg <= '0; key_reg <= '0; cnt_reg <= '0; err_reg <= ERR_NONE;
            m_valid <= 1'b0;
        end else begin
            if (cfg_we) raw_push_reg <= cfg_wdata;
            if (accept) begin
                pos_reg <= pos_next; ph_reg <= ph_next; cop_reg <= cop_next;
                iaddr_reg <= iaddr_next; wide_reg <= wide_next; obl_reg <= obl_next;
                pad_reg <= pad_next; acc_reg <= acc_next; wbc_reg <= wbc_next;
                key_reg <= key_next; cnt_reg <= cnt_next; err_reg <= err_next;
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // Hold the result item until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_byte_offset <= 16'(pos_reg);
            m_error_code  <= err_next;
            if (err_next != ERR_NONE) begin
                m_instr_start <= 1'b0; m_instr_end <= 1'b0; m_opcode <= '0;
                m_is_wide <= 1'b0; m_target_valid <= 1'b0; m_target_kind <= '0;
                m_target <= '0; m_case_key <= '0;
            end else begin
                m_instr_start <= start; m_instr_end <= fin; m_opcode <= cop_next;
                m_is_wide <= wide_next; m_target_valid <= tv; m_target_kind <= kind;
                m_target <= tgt; m_case_key <= key;
            end
        end
    end

endmodule

// ----- bench/jvm_bytecode_boundary_parser_tb.sv -----
`default_nettype none

module jvm_bytecode_boundary_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jbbp_pkg::*;

    localparam int LIMIT_POS = 1 << ADDR_BITS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 670;
    localparam logic [7:0] OP_LSWITCH = 8'hAB;
    localparam logic [7:0] OP_GOTO = 8'hA7;
    localparam logic [7:0] OP_UNDEFINED = 8'hCB;

    typedef struct packed {
        logic [15:0] byte_offset;
        logic        instr_start;
        logic        instr_end;
        logic [7:0]  opcode;
        logic        is_wide;
        logic        target_valid;
        logic [1:0]  target_kind;
        logic [31:0] target;
        logic [31:0] case_key;
        logic [2:0]  error_code;
    } boundary_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_code_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_byte_offset;
    logic        m_instr_start;
    logic        m_instr_end;
    logic [7:0]  m_opcode;
    logic        m_is_wide;
    logic        m_target_valid;
    logic [1:0]  m_target_kind;
    logic [31:0] m_target;
    logic [31:0] m_case_key;
    logic [2:0]  m_error_code;

    jvm_bytecode_boundary_parser DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_code_byte(s_code_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_byte_offset(m_byte_offset),
        .m_instr_start(m_instr_start), .m_instr_end(m_instr_end), .m_opcode(m_opcode),
        .m_is_wide(m_is_wide), .m_target_valid(m_target_valid),
        .m_target_kind(m_target_kind), .m_target(m_target), .m_case_key(m_case_key),
        .m_error_code(m_error_code)
    );

    always #0.5 aclk = ~aclk;

    // Parser shadow state
    logic [7:0]  raw_op = RAW_PUSH_RESET;
    int          pos;
    phase_t      ph;
    logic [7:0]  cur_op;
    logic [15:0] iaddr;
    logic        wide;
    logic [2:0]  opnd_left;
    logic [1:0]  pad_left;
    logic [31:0] acc;
    logic [1:0]  wbyte;
    logic [31:0] run_key;
    logic [31:0] cases_left;
    logic [2:0]  err;
    logic [31:0] planned_word;
    logic [31:0] planned_low;

    boundary_t expected_q[$];
    int        fails = 0;
    int        cycles = 0;
    int        tx_idle = 0;
    int        rx_idle = 0;

    // Opcode class and operand count
    function automatic op_class_t opcode_class(input logic [7:0] b, output int len);
        len = 0;
        if (b == 8'h10 || b == 8'h12 || b == 8'hBC) begin
            len = 1;
            return CL_FIXED;
        end
        if (b == 8'h11 || b == 8'h13 || b == 8'h14 || b == 8'hB6 || b == 8'hBB ||
            b == 8'hBD || b == 8'hC0 || b == 8'hC1) begin
            len = 2;
            return CL_FIXED;
        end
        if (b == 8'hC5) begin
            len = 3;
            return CL_FIXED;
        end
        if (b == 8'hB9 || b == 8'hBA) begin
            len = 4;
            return CL_FIXED;
        end
        if ((b >= 8'h15 && b <= 8'h19) || (b >= 8'h36 && b <= 8'h3A) || b == 8'hA9)
            return CL_LOCAL;
        if (b == OP_IINC) return CL_IINC;
        if ((b >= 8'hB2 && b <= 8'hB5) || b == 8'hB7 || b == 8'hB8) return CL_FIELD;
        if ((b >= 8'h99 && b <= 8'hA8) || b == 8'hC6 || b == 8'hC7) return CL_BR16;
        if (b == OP_GOTO_W || b == OP_JSR_W) return CL_BR32;
        if (b == OP_TSWITCH || b == OP_LSWITCH) return CL_SWITCH;
        if (b <= 8'h35 || (b >= 8'h3B && b <= 8'h98) || (b >= 8'hAC && b <= 8'hB1) ||
            b == 8'hBE || b == 8'hBF || b == 8'hC2 || b == 8'hC3)
            return CL_FIXED;
        return CL_UNKNOWN;
    endfunction

    // Advance the shadow parser by one byte and build its boundary item
    task automatic parse_byte(input logic [7:0] b, output boundary_t r);
        op_class_t c;
        int        len;
        logic      done;
        logic [31:0] ofs;
        r = '0;
        r.byte_offset = pos[15:0];
        done = 1'b0;
        if (err == ERR_NONE && pos >= LIMIT_POS) err = ERR_LONG;
        if (err == ERR_NONE) begin
            case (ph)
                PH_OPCODE, PH_WIDE_OP: begin
                    if (ph == PH_OPCODE) begin
                        iaddr = pos[15:0];
                        wide = 1'b0;
                        r.instr_start = 1'b1;
                    end
                    cur_op = b;
                    if (b == raw_op) begin
                        if (wide) err = ERR_BADWIDE;
                        else begin
                            ph = PH_OPERANDS;
                            opnd_left = 3'd4;
                        end
                    end else if (b == OP_WIDE) begin
                        if (wide) err = ERR_WIDE2;
                        else begin
                            wide = 1'b1;
                            ph = PH_WIDE_OP;
                        end
                    end else begin
                        c = opcode_class(b, len);
                        if (c == CL_UNKNOWN) err = ERR_UNKNOWN;
                        else if (wide && c != CL_LOCAL && c != CL_IINC && c != CL_FIELD)
                            err = ERR_BADWIDE;
                        else begin
                            if (c == CL_LOCAL) len = wide ? 2 : 1;
                            else if (c == CL_IINC) len = wide ? 4 : 2;
                            else if (c == CL_FIELD) len = wide ? 3 : 2;
                            if (c == CL_BR16 || c == CL_BR32) begin
                                ph = PH_BRANCH;
                                opnd_left = (c == CL_BR16) ? 3'd2 : 3'd4;
                                acc = '0;
                            end else if (c == CL_SWITCH) begin
                                pad_left = 2'd3 - iaddr[1:0];
                                acc = '0;
                                wbyte = '0;
                                ph = (pad_left != 0) ? PH_PAD : PH_DEFAULT;
                            end else if (len == 0) begin
                                r.instr_end = 1'b1;
                                ph = PH_OPCODE;
                            end else begin
                                ph = PH_OPERANDS;
                                opnd_left = len[2:0];
                            end
                        end
                    end
                end
                PH_OPERANDS: begin
                    opnd_left = opnd_left - 3'd1;
                    if (opnd_left == 0) begin
                        r.instr_end = 1'b1;
                        ph = PH_OPCODE;
                    end
                end
                PH_BRANCH: begin
                    acc = {acc[23:0], b};
                    opnd_left = opnd_left - 3'd1;
                    if (opnd_left == 0) begin
                        ofs = acc;
                        if (cur_op != OP_GOTO_W && cur_op != OP_JSR_W)
                            ofs = {{16{acc[15]}}, acc[15:0]};
                        r.target_valid = 1'b1;
                        r.target_kind = KIND_BRANCH;
                        r.target = {16'h0, iaddr} + ofs;
                        r.instr_end = 1'b1;
                        ph = PH_OPCODE;
                    end
                end
                PH_PAD: begin
                    pad_left = pad_left - 2'd1;
                    if (pad_left == 0) ph = PH_DEFAULT;
                end
                default: begin
                    acc = {acc[23:0], b};
                    done = (wbyte == 2'd3);
                    wbyte = wbyte + 2'd1;
                end
            endcase
            // Act on a completed offset word
            if (err == ERR_NONE && done) begin
                case (ph)
                    PH_DEFAULT: begin
                        r.target_valid = 1'b1;
                        r.target_kind = KIND_DEFAULT;
                        r.target = {16'h0, iaddr} + acc;
                        ph = (cur_op == OP_TSWITCH) ? PH_TS_LOW : PH_LS_NPAIRS;
                    end
                    PH_TS_LOW: begin
                        run_key = acc;
                        ph = PH_TS_HIGH;
                    end
                    PH_TS_HIGH: begin
                        cases_left = acc - run_key + 32'd1;
                        if (cases_left == 0) begin
                            r.instr_end = 1'b1;
                            ph = PH_OPCODE;
                        end else ph = PH_TS_CASE;
                    end
                    PH_TS_CASE: begin
                        r.target_valid = 1'b1;
                        r.target_kind = KIND_TCASE;
                        r.target = {16'h0, iaddr} + acc;
                        r.case_key = run_key;
                        run_key = run_key + 32'd1;
                        cases_left = cases_left - 32'd1;
                        if (cases_left == 0) begin
                            r.instr_end = 1'b1;
                            ph = PH_OPCODE;
                        end
                    end
                    PH_LS_NPAIRS: begin
                        cases_left = acc;
                        if (cases_left == 0) begin
                            r.instr_end = 1'b1;
                            ph = PH_OPCODE;
                        end else ph = PH_LS_MATCH;
                    end
                    PH_LS_MATCH: begin
                        run_key = acc;
                        ph = PH_LS_OFFSET;
                    end
                    default: begin
                        r.target_valid = 1'b1;
                        r.target_kind = KIND_LPAIR;
                        r.target = {16'h0, iaddr} + acc;
                        r.case_key = run_key;
                        cases_left = cases_left - 32'd1;
                        if (cases_left == 0) begin
                            r.instr_end = 1'b1;
                            ph = PH_OPCODE;
                        end else ph = PH_LS_MATCH;
                    end
                endcase
            end
            r.opcode = cur_op;
            r.is_wide = wide;
        end
        // Blank everything but the offset once an error is held
        if (err != ERR_NONE) begin
            r = '0;
            r.byte_offset = pos[15:0];
        end
        r.error_code = err;
        if (pos < LIMIT_POS) pos++;
    endtask

    // Pick a byte that keeps the method well formed, switch counts kept small
    function automatic logic [7:0] next_code_byte();
        logic [7:0] b;
        int len;
        op_class_t c;
        case (ph)
            PH_OPCODE: begin
                forever begin
                    case ($urandom_range(0, 9))
                        0: b = OP_TSWITCH;
                        1: b = OP_LSWITCH;
                        2: b = OP_WIDE;
                        3: b = ($urandom_range(0, 1) != 0) ? OP_GOTO_W : OP_GOTO;
                        default: b = $urandom_range(0, 255);
                    endcase
                    if (b == raw_op || b == OP_WIDE) return b;
                    if (opcode_class(b, len) != CL_UNKNOWN) return b;
                end
            end
            PH_WIDE_OP: begin
                forever begin
                    b = $urandom_range(0, 255);
                    c = opcode_class(b, len);
                    if (b != raw_op && (c == CL_LOCAL || c == CL_IINC || c == CL_FIELD))
                        return b;
                end
            end
            PH_TS_LOW, PH_TS_HIGH, PH_LS_NPAIRS: begin
                if (wbyte == 0) begin
                    if (ph == PH_TS_LOW) begin
                        case ($urandom_range(0, 4))
                            0: planned_low = 32'h7FFF_FFFE;
                            1: planned_low = 32'hFFFF_FFFF;
                            2: planned_low = 32'h8000_0000;
                            default: planned_low = $urandom;
                        endcase
                        planned_word = planned_low;
                    end else if (ph == PH_TS_HIGH) begin
                        planned_word = planned_low + $urandom_range(0, 4) - 32'd1;
                    end else begin
                        planned_word = $urandom_range(0, 3);
                    end
                end
                return planned_word[31 - 8 * wbyte -: 8];
            end
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic reset_shadow();
        pos = 0;
        ph = PH_OPCODE;
        cur_op = '0;
        iaddr = '0;
        wide = 1'b0;
        opnd_left = '0;
        pad_left = '0;
        acc = '0;
        wbyte = '0;
        run_key = '0;
        cases_left = '0;
        err = ERR_NONE;
    endtask

    // Offer one item; typed rows replace the shadow parser's item
    task automatic send_byte(input logic [7:0] b, input logic typed, input boundary_t fixed);
        boundary_t r;
        while ($urandom_range(0, 99) < tx_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_code_byte = b;
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, r);
        expected_q.push_back(typed ? fixed : r);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Hold off until every pending item has come back
    task automatic drain();
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_raw_push(input logic [7:0] v);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we = 1'b0;
        raw_op = v;
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_byte(next_code_byte(), 1'b0, '0);
            if (i == n / 2 && $urandom_range(0, 1) != 0) drain();
        end
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want,
                          input logic [15:0] ofs);
        $display("mismatch at offset %0d: %s got %h expected %h", ofs, field, got, want);
        fails++;
    endtask

    // Receiver stalls
    always @(negedge aclk) m_ready <= ($urandom_range(0, 99) >= rx_idle);

    // Compare each returned item with the oldest expectation
    always @(posedge aclk) begin
        boundary_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("unexpected item at offset %0d", m_byte_offset);
                fails++;
            end else begin
                want = expected_q.pop_front();
                if (m_byte_offset != want.byte_offset)
                    report("byte_offset", m_byte_offset, want.byte_offset, want.byte_offset);
                if (m_instr_start != want.instr_start)
                    report("instr_start", m_instr_start, want.instr_start, want.byte_offset);
                if (m_instr_end != want.instr_end)
                    report("instr_end", m_instr_end, want.instr_end, want.byte_offset);
                if (m_opcode != want.opcode)
                    report("opcode", m_opcode, want.opcode, want.byte_offset);
                if (m_is_wide != want.is_wide)
                    report("is_wide", m_is_wide, want.is_wide, want.byte_offset);
                if (m_target_valid != want.target_valid)
                    report("target_valid", m_target_valid, want.target_valid, want.byte_offset);
                if (m_target_kind != want.target_kind)
                    report("target_kind", m_target_kind, want.target_kind, want.byte_offset);
                if (m_target != want.target)
                    report("target", m_target, want.target, want.byte_offset);
                if (m_case_key != want.case_key)
                    report("case_key", m_case_key, want.case_key, want.byte_offset);
                if (m_error_code != want.error_code)
                    report("error_code", m_error_code, want.error_code, want.byte_offset);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Directed method: nop, wide iload, wide iinc, goto back, goto_w far, raw push, bipush
    logic [7:0] directed_bytes[26] = '{
        8'h00,
        8'hC4, 8'h15, 8'h12, 8'h34,
        8'hC4, 8'h84, 8'hFF, 8'hFF, 8'h00, 8'h01,
        8'hA7, 8'h80, 8'h00,
        8'hC8, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
        8'hFE, 8'h01, 8'h02, 8'h03, 8'h04,
        8'h10, 8'h80
    };

    initial begin
        boundary_t first_nop;
        boundary_t err_row;
        reset_shadow();
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // First byte after reset: a nop that opens and closes at offset zero
        first_nop = '0;
        first_nop.instr_start = 1'b1;
        first_nop.instr_end = 1'b1;
        first_nop.error_code = ERR_NONE;
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i], i == 0, first_nop);

        // Receiver idles more than the sender
        tx_idle = 38;
        rx_idle = 63;
        write_raw_push(8'h00);
        run_random(PHASE_ITEMS);

        // Sender idles more; raw push collides with tableswitch
        tx_idle = 63;
        rx_idle = 38;
        write_raw_push(OP_TSWITCH);
        run_random(PHASE_ITEMS);

        // No idling at all
        tx_idle = 0;
        rx_idle = 0;
        write_raw_push(8'hFF);
        run_random(PHASE_ITEMS);

        // Raw push collides with the wide prefix
        write_raw_push(OP_WIDE);
        run_random(20);

        // Undefined opcode at an instruction start; the error then holds to the end
        while (ph != PH_OPCODE) send_byte(next_code_byte(), 1'b0, '0);
        err_row = '0;
        err_row.byte_offset = pos[15:0];
        err_row.error_code = ERR_UNKNOWN;
        send_byte(OP_UNDEFINED, 1'b1, err_row);
        repeat (4) send_byte(next_code_byte(), 1'b0, '0);

        drain();
        repeat (5) @(negedge aclk);
        if (fails == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
